/* src/bba_pkg.sv */
package bba_pkg;

    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;
    localparam int BLK_W         = 24;
    localparam int CNT_W         = 13;
    localparam int COUNT_MAX     = 8191;
    localparam int MAP_WORDS_DEF = 128;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 1;

    localparam logic [BLK_W-1:0] FIRST_DATA_BLOCK_RST = 24'd2;
    localparam logic [BLK_W-1:0] FILESYSTEM_SIZE_RST  = 24'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_DATA_BLOCK = 1'b0,
        CFG_FILESYSTEM_SIZE  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

endpackage

/* src/bba_ram.sv */
module bba_ram
    import bba_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = MAP_WORDS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bba_lsb.sv */
module bba_lsb
    import bba_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    output logic [BIT_W-1:0]  o_bit
);

    logic [WORD_W-1:0] iso;

    // isolate the lowest set bit, then encode the one-hot result
    assign iso = i_word & (~i_word + WORD_W'(1));

    always_comb begin
        o_bit = '0;
        for (int b = 0; b < BIT_W; b++) begin
            for (int k = 0; k < WORD_W; k++) begin
                if (((k >> b) & 1) == 1) begin
                    o_bit[b] = o_bit[b] | iso[k];
                end
            end
        end
    end

endmodule

/* src/bitmap_block_allocator.sv */
// Bitmap first-fit block allocator.
// Commands arrive on the s_axis channel: tuser is the command (0 allocate,
// 1 free) and tdata the block number to free. Every command yields exactly
// one result transaction on m_axis: granted block, success flag and the
// free count after the command.
// An allocate scans the free map one word per cycle through the RAM read
// port and takes the lowest free bit of the first nonzero word. A free is
// one read-modify-write of the map word, skipped when the block lies
// outside the map. One command is in work at a time: the next can be
// accepted from the cycle after the result is loaded.
// A result waits in the output register while the receiver stalls; the
// next command is accepted meanwhile and its result holds until the
// register is taken.
// After reset a clearing pass writes every map word to zero, during which
// no command is accepted; configuration writes are taken at any time and
// must only be issued while the block is idle.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // [23:0] block_number
    input  logic                 i_s_axis_tuser,  // [0] command
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // [23:0] granted_block, [24] success,
                                                  // [37:25] free_count, [39:38] zero
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BLK_W-1:0]     i_cfg_wdata
);

    localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFF_W = AW + BIT_W;
    localparam int SUM_W = ((OFF_W > BLK_W) ? OFF_W : BLK_W) + 1;
    localparam int HI_W  = BLK_W - BIT_W;
    localparam logic [AW-1:0]    LAST    = AW'(MAP_WORDS - 1);
    localparam logic [CNT_W-1:0] CNT_LIM =
        CNT_W'((WORD_W * MAP_WORDS > COUNT_MAX) ? COUNT_MAX : WORD_W * MAP_WORDS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FIND,
        S_CHECK,
        S_FRD,
        S_FWR,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [BLK_W-1:0]   r_fdb;
    logic [BLK_W-1:0]   r_fs;
    logic [CNT_W-1:0]   r_free_total;
    logic [CNT_W-1:0]   n_free_total;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      r_scan_addr;
    logic [AW-1:0]      r_chk_addr;
    logic               r_dv;
    logic [AW-1:0]      r_idx;
    logic [BIT_W-1:0]   r_j;
    logic [WORD_W-1:0]  r_word;
    logic               r_hit;
    logic [BLK_W-1:0]   r_res_block;
    logic               r_res_ok;
    logic               r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    logic               s_acc;
    logic [BLK_W-1:0]   off;
    logic               hit;
    logic [SUM_W-1:0]   blk;
    logic               blk_ok;
    logic [WORD_W-1:0]  bit_mask;
    logic [BIT_W-1:0]   lsb_bit;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // free decode: offset into the map and range check
    assign off = i_s_axis_tdata - r_fdb;
    assign hit = (i_s_axis_tdata >= r_fdb) && (off[BLK_W-1:BIT_W] < HI_W'(MAP_WORDS));

    assign blk      = SUM_W'(r_fdb) + SUM_W'({r_idx, r_j});
    assign blk_ok   = blk < SUM_W'(r_fs);
    assign bit_mask = WORD_W'(1) << r_j;

    always_comb begin
        if (t_cmd'(i_s_axis_tuser) == CMD_FREE) begin
            n_free_total = (r_free_total < CNT_LIM) ? r_free_total + CNT_W'(1) : CNT_LIM;
        end else begin
            n_free_total = (r_free_total != '0) ? r_free_total - CNT_W'(1) : r_free_total;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
            end
            S_SCAN: begin
                ram_re    = 1'b1;
                ram_raddr = r_scan_addr;
            end
            S_CHECK: begin
                ram_we    = blk_ok;
                ram_wdata = r_word & ~bit_mask;
            end
            S_FRD: begin
                ram_re = r_hit;
            end
            S_FWR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | bit_mask;
            end
            default: begin
            end
        endcase
    end

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_lsb u_lsb (
        .i_word (r_word),
        .o_bit  (lsb_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdb <= FIRST_DATA_BLOCK_RST;
            r_fs  <= FILESYSTEM_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_DATA_BLOCK: r_fdb <= i_cfg_wdata;
                CFG_FILESYSTEM_SIZE:  r_fs  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_free_total <= '0;
            r_m_valid    <= 1'b0;
            r_dv         <= 1'b0;
        end else begin
            if (r_m_valid && i_m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_free_total <= n_free_total;
                        r_res_block  <= '0;
                        r_res_ok     <= 1'b0;
                        r_scan_addr  <= '0;
                        r_dv         <= 1'b0;
                        r_hit        <= hit;
                        r_idx        <= off[BIT_W +: AW];
                        r_j          <= off[BIT_W-1:0];
                        r_state      <= (t_cmd'(i_s_axis_tuser) == CMD_FREE) ? S_FRD : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one read issued per cycle, the word read last cycle checked
                    if (r_dv && ram_rdata != '0) begin
                        r_word  <= ram_rdata;
                        r_idx   <= r_chk_addr;
                        r_state <= S_FIND;
                    end else if (r_dv && r_chk_addr == LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_dv       <= 1'b1;
                        r_chk_addr <= r_scan_addr;
                        if (r_scan_addr != LAST) begin
                            r_scan_addr <= r_scan_addr + AW'(1);
                        end
                    end
                end
                S_FIND: begin
                    r_j     <= lsb_bit;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (blk_ok) begin
                        r_res_block <= blk[BLK_W-1:0];
                        r_res_ok    <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_FRD: begin
                    r_state <= r_hit ? S_FWR : S_OUT;
                end
                S_FWR: begin
                    r_res_ok <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {2'b00, r_free_total, r_res_ok, r_res_block};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= CNT_LIM)
        else $error("free count above map size");

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[BLK_W-1:0] != '0)
            |-> (o_m_axis_tdata[BLK_W] && o_m_axis_tdata[BLK_W-1:0] < r_fs))
        else $error("granted block outside the filesystem");

    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !s_acc)
        else $error("map write while a command is accepted");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("second command accepted while one is in work");

endmodule
